[src/tepq_pkg.sv]
// Package for the timed event priority queue.
// Holds the operation and status codes and the cell command struct.
// No dependencies.
package tepq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic insert;   // shift the tail right, drop new event at its place
        logic pop;      // shift everything left by one
    } cell_cmd_t;

endpackage

[src/timed_event_priority_queue.sv]
// Top level of the timed event priority queue: a sorted chain of tepq_cell slots.
// Depends on tepq_pkg and tepq_cell.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, operation, event_time,       | sink
//          | event_handle                                    |
//  out     | out_valid/out_ready, found, out_time,           | source
//          | out_handle, status, entry_count                 |
//
// One beat in, one beat out: every cell compares its own time with the
// incoming time in parallel, so insert, pop, peek and clear all finish in
// the accepting cycle and the result is registered.
// A new beat is taken while the output register is empty or being drained.
// Reset empties the queue (count only; slot contents need no clearing).
// A stall on out holds the result and blocks in until it is taken.
module timed_event_priority_queue #(
    parameter int DEPTH       = 16,
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    input  logic [TIME_BITS-1:0]   event_time,
    input  logic [HANDLE_BITS-1:0] event_handle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [TIME_BITS-1:0]   out_time,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       entry_count
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                   accept;
    tepq_pkg::op_t          op;
    tepq_pkg::cell_cmd_t    cmd;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   out_valid_reg;
    logic                   found_reg,   found_next;
    logic [TIME_BITS-1:0]   time_reg,    time_next;
    logic [HANDLE_BITS-1:0] handle_reg,  handle_next;
    tepq_pkg::status_t      status_reg,  status_next;

    // Chain taps.
    logic [TIME_BITS-1:0]   cell_time   [DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
    logic                   cell_keep   [DEPTH];

    logic full;
    logic empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign op       = tepq_pkg::op_t'(operation);
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    // Decode into cell commands and next result.
    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        found_next  = 1'b0;
        time_next   = '0;
        handle_next = '0;
        status_next = tepq_pkg::ST_OK;
        unique case (op)
            tepq_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = tepq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            tepq_pkg::OP_POP,
            tepq_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = tepq_pkg::ST_EMPTY;
                end
                else
                begin
                    found_next  = 1'b1;
                    time_next   = cell_time[0];
                    handle_next = cell_handle[0];
                    if (op == tepq_pkg::OP_POP)
                    begin
                        cmd.pop    = accept;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            tepq_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                   prev_keep;
            logic [TIME_BITS-1:0]   prev_time;
            logic [HANDLE_BITS-1:0] prev_handle;
            logic [TIME_BITS-1:0]   next_time;
            logic [HANDLE_BITS-1:0] next_handle;

            // Head of the chain: the new event always lands at slot 0 if slot 0 moves.
            if (gi == 0)
            begin : g_head
                assign prev_keep   = 1'b1;
                assign prev_time   = event_time;
                assign prev_handle = event_handle;
            end
            else
            begin : g_body
                assign prev_keep   = cell_keep[gi-1];
                assign prev_time   = cell_time[gi-1];
                assign prev_handle = cell_handle[gi-1];
            end

            // Tail: the vacated last slot is beyond the count after a pop.
            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_time   = cell_time[gi];
                assign next_handle = cell_handle[gi];
            end
            else
            begin : g_link
                assign next_time   = cell_time[gi+1];
                assign next_handle = cell_handle[gi+1];
            end

            tepq_cell #(
                .TIME_BITS   (TIME_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (CNT_W'(gi) < count_reg),
                .new_time    (event_time),
                .new_handle  (event_handle),
                .prev_keep   (prev_keep),
                .prev_time   (prev_time),
                .prev_handle (prev_handle),
                .next_time   (next_time),
                .next_handle (next_handle),
                .keep        (cell_keep[gi]),
                .slot_time   (cell_time[gi]),
                .slot_handle (cell_handle[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: loaded on accept, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found_next;
            time_reg   <= time_next;
            handle_reg <= handle_next;
            status_reg <= status_next;
        end
    end

    logic [CNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_out_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign out_time    = time_reg;
    assign out_handle  = handle_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;

endmodule

[src/tepq_cell.sv]
// One slot of the sorted event chain.
// Depends on tepq_pkg (cell_cmd_t).
module tepq_cell #(
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                      clk,
    input  tepq_pkg::cell_cmd_t       cmd,
    input  logic                      occupied,
    input  logic [TIME_BITS-1:0]      new_time,
    input  logic [HANDLE_BITS-1:0]    new_handle,
    input  logic                      prev_keep,
    input  logic [TIME_BITS-1:0]      prev_time,
    input  logic [HANDLE_BITS-1:0]    prev_handle,
    input  logic [TIME_BITS-1:0]      next_time,
    input  logic [HANDLE_BITS-1:0]    next_handle,
    output logic                      keep,
    output logic [TIME_BITS-1:0]      slot_time,
    output logic [HANDLE_BITS-1:0]    slot_handle
);

    logic [TIME_BITS-1:0]   time_reg;
    logic [TIME_BITS-1:0]   time_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;

    // Held event stays put when it is no later than the new one (ties: older first).
    assign keep = occupied && (time_reg <= new_time);

    // Insert and pop never come together; with neither the slot holds.
    always_comb
    begin
        time_next   = time_reg;
        handle_next = handle_reg;
        if (cmd.insert)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    time_next   = new_time;
                    handle_next = new_handle;
                end
                else
                begin
                    time_next   = prev_time;
                    handle_next = prev_handle;
                end
            end
        end
        else if (cmd.pop)
        begin
            time_next   = next_time;
            handle_next = next_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        handle_reg <= handle_next;
    end

    assign slot_time   = time_reg;
    assign slot_handle = handle_reg;

endmodule

[src/tepq_checker.sv]
// Port-level checker for the timed event priority queue, bound to the top level.
// Depends on tepq_pkg and timed_event_priority_queue.
module tepq_checker #(
    parameter int DEPTH       = 16,
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16,
    parameter int CNT_W       = 5
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [1:0]             operation,
    input logic                   out_valid,
    input logic                   found,
    input logic [TIME_BITS-1:0]   out_time,
    input logic [HANDLE_BITS-1:0] out_handle,
    input logic [1:0]             status,
    input logic [CNT_W-1:0]       entry_count
);

    // A clear is answered in the next cycle with an empty queue.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == tepq_pkg::OP_CLEAR) |=>
        (out_valid && entry_count == '0 && status == tepq_pkg::ST_OK))
        else $error("clear did not empty the queue");

    // A returned event means status ok; otherwise the event fields are zero.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (out_time == '0 && out_handle == '0))
        else $error("event fields nonzero without an event");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == tepq_pkg::ST_OK && entry_count != '0
                                   || status == tepq_pkg::ST_OK))
        else $error("event returned with error status");

    // Full reject only at capacity; empty report only with nothing held.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tepq_pkg::ST_FULL) |-> (entry_count == CNT_W'(DEPTH)))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tepq_pkg::ST_EMPTY) |-> (entry_count == '0 && !found))
        else $error("empty reported with events held");

endmodule

bind timed_event_priority_queue tepq_checker #(
    .DEPTH       (DEPTH),
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .CNT_W       (CNT_W)
) u_tepq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .out_valid   (out_valid),
    .found       (found),
    .out_time    (out_time),
    .out_handle  (out_handle),
    .status      (status),
    .entry_count (entry_count)
);

[dv/testbench.sv]
// Self-checking testbench for the timed event priority queue (timed_event_priority_queue).
// Uses tepq_pkg for the operation and status codes; needs only the RTL under src.
// A scoreboard model predicts each result, and random stalls land on both channels.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int TIME_BITS   = 32;
    localparam int HANDLE_BITS = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // No accepted beat on either side for this many cycles means the block hung.
    localparam int HANG_LIMIT  = 2000;
    // Random items after the directed opening.
    localparam int RANDOM_ITEMS = 1800;
    // The result is registered; the tail adds margin to catch strays.
    localparam int TAIL_CYCLES = 10;
    // Cap on mismatch lines so a broken build does not flood the log.
    localparam int MAX_REPORTS = 60;

    // One input beat waiting to be driven. A drain point carries no beat: the
    // sender holds off until every expected result has come back.
    typedef struct {
        tepq_pkg::op_t          op;
        logic [TIME_BITS-1:0]   stamp;
        logic [HANDLE_BITS-1:0] handle;
        int                     gap_after;
        bit                     drain_point;
    } stim_beat_t;

    // One result beat as the block should produce it.
    typedef struct {
        logic                   found;
        logic [TIME_BITS-1:0]   stamp;
        logic [HANDLE_BITS-1:0] handle;
        tepq_pkg::status_t      status;
        logic [CNT_W-1:0]       count;
    } queue_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             operation = tepq_pkg::OP_INSERT;
    logic [TIME_BITS-1:0]   event_time = '0;
    logic [HANDLE_BITS-1:0] event_handle = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   found;
    logic [TIME_BITS-1:0]   out_time;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [1:0]             status;
    logic [CNT_W-1:0]       entry_count;

    stim_beat_t    pending_beats[$];
    queue_result_t awaited_results[$];

    // Shadow copy of the event store, earliest first.
    logic [TIME_BITS-1:0]   shadow_time[DEPTH];
    logic [HANDLE_BITS-1:0] shadow_handle[DEPTH];
    int                     shadow_count = 0;

    int  error_count = 0;
    int  hang_cycles = 0;
    int  cycle_count = 0;
    bit  in_beat_taken = 1'b0;
    int  send_idle_left = 0;
    int  sink_stall_left = 0;

    timed_event_priority_queue #(
        .DEPTH       (DEPTH),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .event_time   (event_time),
        .event_handle (event_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .out_time     (out_time),
        .out_handle   (out_handle),
        .status       (status),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Gap length: mostly short, now and then long.
    function automatic int stall_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 92)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int sender_gap();
        if ($urandom_range(0, 99) < 30)
            return stall_length();
        return 0;
    endfunction

    // Narrow stamps force runs of equal times, which exercise the tie order.
    function automatic logic [TIME_BITS-1:0] pick_stamp(bit narrow);
        int unsigned pick;
        if (narrow)
            return $urandom_range(0, 7);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick == 2)
            return 32'hFFFF_FFF8 + $urandom_range(0, 7);
        return $urandom();
    endfunction

    // Applies one accepted beat to the shadow store and returns the result
    // the block owes for it. Insert goes after every held event with a time
    // less than or equal to its own, so ties leave in arrival order.
    function automatic queue_result_t schedule_outcome(tepq_pkg::op_t op,
                                                       logic [TIME_BITS-1:0] stamp,
                                                       logic [HANDLE_BITS-1:0] handle);
        queue_result_t res;
        int            pos;
        res.found  = 1'b0;
        res.stamp  = '0;
        res.handle = '0;
        res.status = tepq_pkg::ST_OK;
        case (op)
            tepq_pkg::OP_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    res.status = tepq_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_time[pos] <= stamp)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_time[i]   = shadow_time[i-1];
                        shadow_handle[i] = shadow_handle[i-1];
                    end
                    shadow_time[pos]   = stamp;
                    shadow_handle[pos] = handle;
                    shadow_count++;
                end
            end
            tepq_pkg::OP_CLEAR:
                shadow_count = 0;
            default:
            begin
                // pop and peek share the empty check and the head read
                if (shadow_count == 0)
                    res.status = tepq_pkg::ST_EMPTY;
                else
                begin
                    res.found  = 1'b1;
                    res.stamp  = shadow_time[0];
                    res.handle = shadow_handle[0];
                    if (op == tepq_pkg::OP_POP)
                    begin
                        for (int i = 1; i < shadow_count; i++)
                        begin
                            shadow_time[i-1]   = shadow_time[i];
                            shadow_handle[i-1] = shadow_handle[i];
                        end
                        shadow_count--;
                    end
                end
            end
        endcase
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    function automatic void check_field(string name, logic [TIME_BITS-1:0] expected_val,
                                        logic [TIME_BITS-1:0] actual_val);
        if (actual_val !== expected_val)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: mismatch on %s, expected %0h, actual %0h",
                         $time, name, expected_val, actual_val);
        end
    endfunction

    task automatic queue_beat(tepq_pkg::op_t op, logic [TIME_BITS-1:0] stamp,
                              logic [HANDLE_BITS-1:0] handle, int gap_after);
        stim_beat_t beat;
        beat.op          = op;
        beat.stamp       = stamp;
        beat.handle      = handle;
        beat.gap_after   = gap_after;
        beat.drain_point = 1'b0;
        pending_beats.push_back(beat);
    endtask

    task automatic queue_drain_point();
        stim_beat_t beat;
        beat.op          = tepq_pkg::OP_PEEK;
        beat.stamp       = '0;
        beat.handle      = '0;
        beat.gap_after   = 0;
        beat.drain_point = 1'b1;
        pending_beats.push_back(beat);
    endtask

    // Sender: changes on the falling edge. A beat stays up, unchanged, until
    // the rising edge that accepts it; only then may a gap or the next beat follow.
    always @(negedge clk)
    begin : sender
        stim_beat_t beat;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_beat_taken)
            ;
        else if (send_idle_left > 0)
        begin
            in_valid <= 1'b0;
            send_idle_left--;
        end
        else if (pending_beats.size() == 0)
            in_valid <= 1'b0;
        else if (pending_beats[0].drain_point)
        begin
            // hold off until the block has handed back every owed result
            in_valid <= 1'b0;
            if (awaited_results.size() == 0)
                void'(pending_beats.pop_front());
        end
        else
        begin
            beat = pending_beats.pop_front();
            in_valid       <= 1'b1;
            operation      <= beat.op;
            event_time     <= beat.stamp;
            event_handle   <= beat.handle;
            send_idle_left = beat.gap_after;
        end
    end

    // Receiver: ready drops for random stretches, except in calm windows
    // where it stays high so back-to-back beats flow at full rate.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (sink_stall_left > 0)
        begin
            out_ready <= 1'b0;
            sink_stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ((cycle_count / 1500) % 3 != 0 && $urandom_range(0, 99) < 25)
                sink_stall_left = stall_length();
        end
    end

    // Monitor, scoreboard and watchdog, all on the rising edge. The result
    // register means an output beat always belongs to an earlier input beat,
    // so it is checked before the input beat of the same edge is predicted.
    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        bit            out_beat;
        if (rst_n)
        begin
            cycle_count++;
            in_beat_taken = in_valid && in_ready;
            out_beat      = out_valid && out_ready;
            if (out_beat)
            begin
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, status %0h count %0d",
                                 $time, status, entry_count);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("found", TIME_BITS'(want.found), TIME_BITS'(found));
                    check_field("out_time", want.stamp, out_time);
                    check_field("out_handle", TIME_BITS'(want.handle),
                                TIME_BITS'(out_handle));
                    check_field("status", TIME_BITS'(want.status), TIME_BITS'(status));
                    check_field("entry_count", TIME_BITS'(want.count),
                                TIME_BITS'(entry_count));
                end
            end
            if (in_beat_taken)
                awaited_results.push_back(schedule_outcome(tepq_pkg::op_t'(operation),
                                                           event_time, event_handle));
            if (in_beat_taken || out_beat)
                hang_cycles = 0;
            else
            begin
                hang_cycles++;
                if (hang_cycles >= HANG_LIMIT)
                begin
                    $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
                    $display("FAIL timed_event_priority_queue");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned   pick;
        int            phase;
        int            burst;
        int            random_count;
        bit            narrow;
        bit            calm;
        tepq_pkg::op_t op;

        // Directed opening: empty-queue ops, extremes, ties, a full queue.
        queue_beat(tepq_pkg::OP_POP, '0, '0, 0);
        queue_beat(tepq_pkg::OP_PEEK, '1, '1, 1);
        queue_beat(tepq_pkg::OP_CLEAR, '0, '0, 0);             // clear when already empty
        queue_beat(tepq_pkg::OP_INSERT, '1, '1, 0);            // latest possible time
        queue_beat(tepq_pkg::OP_INSERT, '0, '0, 2);            // earliest possible time
        queue_beat(tepq_pkg::OP_INSERT, 32'd7, 16'hAAAA, 0);   // three equal times, in order
        queue_beat(tepq_pkg::OP_INSERT, 32'd7, 16'h5555, 0);
        queue_beat(tepq_pkg::OP_INSERT, 32'd7, 16'h1234, 0);
        for (int i = 0; i < DEPTH - 5; i++)
            queue_beat(tepq_pkg::OP_INSERT, pick_stamp((i % 2) == 1),
                       HANDLE_BITS'($urandom_range(0, 65535)), 0);
        queue_beat(tepq_pkg::OP_INSERT, 32'd1, 16'hBEEF, 0);   // rejected, queue is full
        queue_beat(tepq_pkg::OP_PEEK, '0, '0, 0);
        queue_beat(tepq_pkg::OP_POP, '0, '0, 0);
        queue_beat(tepq_pkg::OP_POP, '0, '0, 3);
        queue_beat(tepq_pkg::OP_CLEAR, '1, '1, 0);
        queue_beat(tepq_pkg::OP_POP, '0, '0, 0);               // empty again after clear
        queue_drain_point();

        // Random bursts, each with a bias: fill toward full, mixed, drain toward
        // empty, or plain noise. Clears show up now and then in every bias.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            phase  = $urandom_range(0, 9);
            narrow = ($urandom_range(0, 2) == 0);
            calm   = ($urandom_range(0, 3) == 0);
            burst  = $urandom_range(10, 60);
            for (int k = 0; k < burst; k++)
            begin
                pick = $urandom_range(0, 99);
                if (phase <= 3)
                    op = (pick < 80) ? tepq_pkg::OP_INSERT : (pick < 90) ? tepq_pkg::OP_POP
                       : (pick < 97) ? tepq_pkg::OP_PEEK : tepq_pkg::OP_CLEAR;
                else if (phase <= 6)
                    op = (pick < 45) ? tepq_pkg::OP_INSERT : (pick < 80) ? tepq_pkg::OP_POP
                       : (pick < 95) ? tepq_pkg::OP_PEEK : tepq_pkg::OP_CLEAR;
                else if (phase <= 8)
                    op = (pick < 15) ? tepq_pkg::OP_INSERT : (pick < 80) ? tepq_pkg::OP_POP
                       : (pick < 95) ? tepq_pkg::OP_PEEK : tepq_pkg::OP_CLEAR;
                else
                    op = tepq_pkg::op_t'($urandom_range(0, 3));
                queue_beat(op, pick_stamp(narrow), HANDLE_BITS'($urandom_range(0, 65535)),
                           calm ? 0 : sender_gap());
            end
            random_count += burst;
            if ($urandom_range(0, 7) == 0)
                queue_drain_point();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last beat to go in and every owed result to come out.
        while (pending_beats.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("PASS timed_event_priority_queue");
        else
            $display("FAIL timed_event_priority_queue");
        $finish;
    end

endmodule
